@@ src/tmce_pkg.sv @@
package tmce_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int TAB_STOP   = 4;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_MOVE  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'd1;

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_BLANK = 8'h20;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
    localparam logic [CELL_W-1:0]  RESET_BLANK = {BG_RESET, FG_RESET, CHAR_BLANK};

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_data;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic exec_put;
        logic exec_clear;
        logic exec_move;
        logic exec_read;
        logic scr_rd;
        logic scr_wr;
        logic fill;
        logic init;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       scroll_need;
        logic       idx_copy_last;
        logic       idx_last;
        logic       out_free;
    } sts_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

@@ src/text_mode_console_engine.sv @@
// Channel | Dir | Handshake         | Payload
// s_      | in  | s_valid / s_ready | s_item (op, char_code, column, row)
// m_      | out | m_valid / m_ready | m_item (cursor_position, cell_data)
// cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
// Put, move and read pass through capture, execute and load (IDLE, EXEC, DONE); the load
// into the result register waits until that register is free.
// Clear fills every cell with a blank, one cell written per cycle through the store's write port.
// A scroll moves each cell up one row and then blanks the last row: each cell moved is a read, then
// a write, on the single-read, single-write cell store.
// After reset the store is swept to blanks with s_ready low.
// The result register holds while m_ready is low; the next item is taken once it is loaded.
module text_mode_console_engine #(
    parameter int COLUMNS = tmce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmce_pkg::DEF_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tmce_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tmce_pkg::out_item_t             m_item,
    input  logic                            cfg_we,
    input  logic [tmce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmce_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tmce_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tmce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tmce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ src/tmce_ctrl.sv @@
module tmce_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tmce_pkg::sts_t sts,
    output tmce_pkg::cmd_t cmd
);
    import tmce_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (sts.idx_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (sts.op)
                    OP_PUT:   state_next = sts.scroll_need ? ST_SCR_RD : ST_DONE;
                    OP_CLEAR: state_next = ST_FILL;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SCR_RD: begin
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                state_next = sts.idx_copy_last ? ST_FILL : ST_SCR_RD;
            end
            ST_FILL: begin
                if (sts.idx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.init = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_EXEC: begin
                case (sts.op)
                    OP_PUT:   cmd.exec_put   = 1'b1;
                    OP_CLEAR: cmd.exec_clear = 1'b1;
                    OP_MOVE:  cmd.exec_move  = 1'b1;
                    default:  cmd.exec_read  = 1'b1;
                endcase
            end
            ST_SCR_RD: begin
                cmd.scr_rd = 1'b1;
            end
            ST_SCR_WR: begin
                cmd.scr_wr = 1'b1;
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
            end
            ST_DONE: begin
                cmd.out_load = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ src/tmce_datapath.sv @@
module tmce_datapath #(
    parameter int COLUMNS = tmce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmce_pkg::DEF_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tmce_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tmce_pkg::out_item_t                 m_item,
    input  logic                                cfg_we,
    input  logic [tmce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmce_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  tmce_pkg::cmd_t                      cmd,
    output tmce_pkg::sts_t                      sts
);
    import tmce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CXW   = CW + 1;
    localparam int RXW   = RW + 1;
    localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

    logic [CELL_W-1:0] cell_mem [CELLS];

    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic [CW-1:0]      cur_col_reg, cur_col_next;
    logic [RW-1:0]      cur_row_reg, cur_row_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               m_valid_reg, m_valid_next;

    logic [1:0]         op_reg;
    logic [7:0]         char_reg;
    logic [CW-1:0]      mv_col_reg;
    logic [RW-1:0]      mv_row_reg;
    logic [CELL_W-1:0]  rd_data_reg;
    out_item_t          m_item_reg;

    logic [CW-1:0]      in_col_clamp;
    logic [RW-1:0]      in_row_clamp;
    logic [AW-1:0]      cur_addr;
    logic [AW-1:0]      mv_addr;
    logic               is_ctrl;
    logic [CXW-1:0]     col_x, col_step;
    logic [RXW-1:0]     row_x, row_step;
    logic               scroll_need;
    logic [CW-1:0]      put_col;
    logic [RW-1:0]      put_row;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               out_free;

    // saturate the requested position at the screen edge
    assign in_col_clamp = (s_item.column > 7'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                            : s_item.column[CW-1:0];
    assign in_row_clamp = (s_item.row > 5'(ROWS - 1)) ? RW'(ROWS - 1)
                                                      : s_item.row[RW-1:0];

    assign cur_addr = AW'(cur_row_reg) * COLS_A + AW'(cur_col_reg);
    assign mv_addr  = AW'(mv_row_reg) * COLS_A + AW'(mv_col_reg);

    assign is_ctrl = (char_reg == CHAR_NL) || (char_reg == CHAR_TAB) || (char_reg == CHAR_CR);

    always_comb begin
        col_x    = CXW'(cur_col_reg);
        row_x    = RXW'(cur_row_reg);
        row_step = row_x;
        if (char_reg == CHAR_NL) begin
            col_step = '0;
            row_step = row_x + RXW'(1);
        end else if (char_reg == CHAR_TAB) begin
            col_step = (col_x + CXW'(TAB_STOP)) & ~CXW'(TAB_STOP - 1);
        end else if (char_reg == CHAR_CR) begin
            col_step = '0;
        end else begin
            col_step = col_x + CXW'(1);
        end
        // wrap at line end
        if (col_step >= CXW'(COLUMNS)) begin
            col_step = '0;
            row_step = row_x + RXW'(1);
        end
        scroll_need = (row_step >= RXW'(ROWS));
        put_col     = col_step[CW-1:0];
        put_row     = scroll_need ? RW'(ROWS - 1) : row_step[RW-1:0];
    end

    assign mem_we = (cmd.exec_put && !is_ctrl) || cmd.scr_wr || cmd.fill || cmd.init;
    assign mem_re = cmd.exec_read || cmd.scr_rd;

    always_comb begin
        mem_waddr = idx_reg;
        mem_wdata = {bg_reg, fg_reg, CHAR_BLANK};
        if (cmd.exec_put) begin
            mem_waddr = cur_addr;
            mem_wdata = {bg_reg, fg_reg, char_reg};
        end else if (cmd.scr_wr) begin
            mem_wdata = rd_data_reg;
        end else if (cmd.init) begin
            mem_wdata = RESET_BLANK;
        end
    end

    // scroll copies the cell one row below into the current index
    assign mem_raddr = cmd.exec_read ? mv_addr : (idx_reg + COLS_A);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_FG_COLOR: fg_next = cfg_wdata;
                REG_BG_COLOR: bg_next = cfg_wdata;
                default:      fg_next = fg_reg;
            endcase
        end
        if (cmd.exec_put) begin
            cur_col_next = put_col;
            cur_row_next = put_row;
            idx_next     = '0;
        end
        if (cmd.exec_clear) begin
            cur_col_next = '0;
            cur_row_next = '0;
            idx_next     = '0;
        end
        if (cmd.exec_move) begin
            cur_col_next = mv_col_reg;
            cur_row_next = mv_row_reg;
        end
        if (cmd.scr_wr || cmd.fill || cmd.init) begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg      <= FG_RESET;
            bg_reg      <= BG_RESET;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= s_item.op;
            char_reg   <= s_item.char_code;
            mv_col_reg <= in_col_clamp;
            mv_row_reg <= in_row_clamp;
        end
        if (cmd.out_load) begin
            m_item_reg.cursor_position <= POS_W'(cur_addr);
            m_item_reg.cell_data       <= (op_reg == OP_READ) ? rd_data_reg : '0;
        end
    end

    assign sts.op            = op_reg;
    assign sts.scroll_need   = scroll_need;
    assign sts.idx_copy_last = (idx_reg == AW'(CELLS - COLUMNS - 1));
    assign sts.idx_last      = (idx_reg == AW'(CELLS - 1));
    assign sts.out_free      = out_free;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
